>>> sv/pmkc_pkg.sv
// ----------------------------------------------------------------------------
// pmkc_pkg
// Shared types and constants for the PMKID cache table.
// ----------------------------------------------------------------------------
package pmkc_pkg;

    localparam int BSSID_W = 48;
    localparam int KEY_W   = 64;
    localparam int SLOT_W  = 4;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_FLUSH   = 2'd2,
        OP_UNKNOWN = 2'd3
    } t_op;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic               in_use;
        logic [KEY_W-1:0]   key_high;
        logic [KEY_W-1:0]   key_low;
        logic [BSSID_W-1:0] bssid;
    } t_entry;

endpackage

>>> sv/pmkc_store.sv
// ----------------------------------------------------------------------------
// pmkc_store
// Entry memory with one registered read port and one write port. A valid
// bit per entry gives the all-zero reset and flush; invalid entries read zero.
// ----------------------------------------------------------------------------
module pmkc_store #(
    parameter int ENTRIES = 16,
    parameter int AW      = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_flush,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  pmkc_pkg::t_entry  i_wr_data,
    output pmkc_pkg::t_entry  o_rd_data
);

    pmkc_pkg::t_entry r_mem [ENTRIES];
    pmkc_pkg::t_entry r_rd_data;
    logic [ENTRIES-1:0] r_valid;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_flush) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

>>> sv/pmkid_cache_table.sv
// ----------------------------------------------------------------------------
// pmkid_cache_table
// Round-robin PMKSA cache: add, remove and flush commands over an entry memory.
// ----------------------------------------------------------------------------
// One command is taken at a time. Add and remove scan the entry memory from
// entry 0, one read per cycle, stopping at the first BSSID match; the
// longest command is one whose scan through the single read port runs to
// the last entry. Flush, unknown commands and add with a zero BSSID skip
// the scan and go straight to the result. The result waits in an output
// register, so a new command is taken while it is still pending.
module pmkid_cache_table #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [175:0] s_axis_tdata,   // bssid[47:0], pmkid_high[111:48], pmkid_low[175:112]
    input  logic [1:0]   s_axis_tuser,   // operation[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // slot[3:0], zero[7:4]
    output logic         m_axis_tuser    // accepted[0]
);

    localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(CACHE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    pmkc_pkg::t_op                  r_op;
    logic [pmkc_pkg::BSSID_W-1:0]   r_bssid;
    logic [pmkc_pkg::KEY_W-1:0]     r_key_high, r_key_low;
    logic [pmkc_pkg::KEY_W-1:0]     r_hold_high, r_hold_low, n_hold_high, n_hold_low;
    logic [AW-1:0] r_next, n_next;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_chk_idx, n_chk_idx;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_issue, n_issue;
    logic          r_chk, n_chk;
    logic          r_found, n_found;
    logic          r_res_acc, n_res_acc;
    pmkc_pkg::t_slot r_res_slot, n_res_slot;
    logic          r_out_valid, n_out_valid;
    logic          r_out_acc, n_out_acc;
    pmkc_pkg::t_slot r_out_slot, n_out_slot;

    logic              in_acc;
    pmkc_pkg::t_op     in_op;
    logic [pmkc_pkg::BSSID_W-1:0] in_bssid;
    logic              flush;
    logic              rd_en;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    pmkc_pkg::t_entry  wr_data;
    pmkc_pkg::t_entry  rd_data;

    assign in_op    = pmkc_pkg::t_op'(s_axis_tuser);
    assign in_bssid = s_axis_tdata[47:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign flush    = in_acc && (in_op == pmkc_pkg::OP_FLUSH);
    assign rd_en    = (r_state == S_SCAN) && r_issue;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == LAST) ? '0 : idx + 1'b1;
    endfunction

    pmkc_store #(
        .ENTRIES (CACHE_ENTRIES),
        .AW      (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_flush   (flush),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_next      = r_next;
        n_rd_idx    = r_rd_idx;
        n_chk_idx   = r_chk_idx;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_chk       = 1'b0;
        n_found     = r_found;
        n_hold_high = r_hold_high;
        n_hold_low  = r_hold_low;
        n_res_acc   = r_res_acc;
        n_res_slot  = r_res_slot;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_acc   = r_out_acc;
        n_out_slot  = r_out_slot;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_acc  = 1'b0;
                    n_res_slot = '0;
                    n_state    = S_DONE;
                    unique case (in_op)
                        pmkc_pkg::OP_ADD: begin
                            if (in_bssid != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        pmkc_pkg::OP_REMOVE: begin
                            n_state = S_SCAN;
                        end
                        pmkc_pkg::OP_FLUSH: begin
                            n_next    = '0;
                            n_res_acc = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    n_issue  = 1'b1;
                    n_rd_idx = '0;
                end
            end
            S_SCAN: begin
                if (r_issue) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_rd_idx;
                    n_issue   = (r_rd_idx != LAST);
                    n_rd_idx  = wrap_inc(r_rd_idx);
                end
                if (r_chk) begin
                    if (rd_data.bssid == r_bssid) begin
                        n_found     = 1'b1;
                        n_idx       = r_chk_idx;
                        n_hold_high = rd_data.key_high;
                        n_hold_low  = rd_data.key_low;
                        n_chk       = 1'b0;
                        n_state     = S_WRITE;
                    end else if (r_chk_idx == LAST) begin
                        n_found = 1'b0;
                        n_chk   = 1'b0;
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                n_res_acc  = 1'b1;
                n_res_slot = '0;
                n_state    = S_DONE;
                if (r_op == pmkc_pkg::OP_ADD) begin
                    wr_en            = 1'b1;
                    wr_addr          = r_found ? r_idx : r_next;
                    wr_data.in_use   = 1'b1;
                    wr_data.key_high = r_key_high;
                    wr_data.key_low  = r_key_low;
                    wr_data.bssid    = r_bssid;
                    n_next           = wrap_inc(wr_addr);
                    n_res_slot       = pmkc_pkg::t_slot'(wr_addr);
                end else if (r_found) begin
                    wr_en            = 1'b1;
                    wr_addr          = r_idx;
                    wr_data.key_high = r_hold_high;
                    wr_data.key_low  = r_hold_low;
                    n_res_slot       = pmkc_pkg::t_slot'(r_idx);
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_res_acc;
                    n_out_slot  = r_res_slot;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next      <= '0;
            r_issue     <= 1'b0;
            r_chk       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_issue     <= n_issue;
            r_chk       <= n_chk;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= in_op;
            r_bssid    <= in_bssid;
            r_key_high <= s_axis_tdata[111:48];
            r_key_low  <= s_axis_tdata[175:112];
        end
        r_rd_idx    <= n_rd_idx;
        r_chk_idx   <= n_chk_idx;
        r_idx       <= n_idx;
        r_hold_high <= n_hold_high;
        r_hold_low  <= n_hold_low;
        r_res_acc   <= n_res_acc;
        r_res_slot  <= n_res_slot;
        r_out_acc   <= n_out_acc;
        r_out_slot  <= n_out_slot;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8 - pmkc_pkg::SLOT_W){1'b0}}, r_out_slot};
    assign m_axis_tuser  = r_out_acc;

`ifndef SYNTH
    a_zero_add_skips_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == pmkc_pkg::OP_ADD && in_bssid == '0) |=> (r_state == S_DONE))
        else $error("add with zero bssid entered scan");

    a_rejected_has_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_acc) |-> (r_out_slot == '0))
        else $error("rejected command reports a slot");

    a_pointer_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= LAST)
        else $error("round-robin pointer out of range");

    a_write_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_state == S_DONE && !r_chk))
        else $error("entry write not followed by result");
`endif

endmodule
